// ===== design/lsmq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the linked segment multi queue.
// No dependencies; the controller, datapath, top and checker import this package.
package lsmq_pkg;

    localparam logic [1:0] CMD_CREATE  = 2'd0;
    localparam logic [1:0] CMD_DESTROY = 2'd1;
    localparam logic [1:0] CMD_ENQ     = 2'd2;
    localparam logic [1:0] CMD_DEQ     = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OOM     = 2'd1;
    localparam logic [1:0] STAT_ILLEGAL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_EVAL,
        S_ENQ_TAKE,
        S_DEQ_READ,
        S_LINK,
        S_DST_READ,
        S_DST_FREE,
        S_DST_QUEUE,
        S_DST_QLINK,
        S_DONE
    } fsm_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOOKUP,
        OP_EVAL,
        OP_ENQ_TAKE,
        OP_DEQ_READ,
        OP_LINK,
        OP_DST_READ,
        OP_DST_FREE,
        OP_DST_QUEUE,
        OP_DST_QLINK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
        logic   load_out;
    } dp_ctrl_t;

    typedef struct packed {
        logic go_take;
        logic go_deq;
        logic go_dst;
        logic deq_rel;
        logic enq_link;
        logic is_dst;
        logic dst_end;
    } dp_flags_t;

endpackage

// ===== design/lsmq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lsmq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: command sequencing state machine and output word valid.
// Depends on lsmq_pkg.
module lsmq_ctrl
    import lsmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  dp_flags_t flags,
    output dp_ctrl_t  ctrl
);

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       load;

    assign accept = (state_reg == S_IDLE) && in_valid;
    assign load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_LOOKUP;
            S_LOOKUP:    state_next = S_EVAL;
            S_EVAL:
            begin
                priority if (flags.go_take) state_next = S_ENQ_TAKE;
                else if (flags.go_deq)      state_next = S_DEQ_READ;
                else if (flags.go_dst)      state_next = S_DST_READ;
                else                        state_next = S_DONE;
            end
            S_ENQ_TAKE:  state_next = flags.enq_link ? S_LINK : S_DONE;
            S_DEQ_READ:  state_next = flags.deq_rel ? S_LINK : S_DONE;
            S_LINK:      state_next = flags.is_dst ? S_DST_READ : S_DONE;
            S_DST_READ:  state_next = flags.dst_end ? S_DST_QUEUE : S_DST_FREE;
            S_DST_FREE:  state_next = S_LINK;
            S_DST_QUEUE: state_next = S_DST_QLINK;
            S_DST_QLINK: state_next = S_DONE;
            S_DONE:      if (load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.accept   = accept;
        ctrl.load_out = load;
        unique case (state_reg)
            S_LOOKUP:    ctrl.op = OP_LOOKUP;
            S_EVAL:      ctrl.op = OP_EVAL;
            S_ENQ_TAKE:  ctrl.op = OP_ENQ_TAKE;
            S_DEQ_READ:  ctrl.op = OP_DEQ_READ;
            S_LINK:      ctrl.op = OP_LINK;
            S_DST_READ:  ctrl.op = OP_DST_READ;
            S_DST_FREE:  ctrl.op = OP_DST_FREE;
            S_DST_QUEUE: ctrl.op = OP_DST_QUEUE;
            S_DST_QLINK: ctrl.op = OP_DST_QLINK;
            default:     ctrl.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/lsmq_dp.sv =====
`timescale 1ns / 1ps
// Datapath: queue and segment tables, free lists and result registers.
// Depends on lsmq_pkg and lsmq_ram.
module lsmq_dp
    import lsmq_pkg::*;
#(
    parameter int NUM_SEGMENTS = 128,
    parameter int SEG_BYTES    = 16,
    parameter int NUM_QUEUES   = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_ctrl_t   ctrl,
    output dp_flags_t  flags,
    input  logic [1:0] cmd,
    input  logic [5:0] queue_id,
    input  logic [7:0] data_byte,
    output logic [1:0] status,
    output logic [5:0] new_queue_id,
    output logic [7:0] read_byte
);

    localparam int SW  = $clog2(NUM_SEGMENTS + 1);
    localparam int SIW = $clog2(NUM_SEGMENTS);
    localparam int QW  = $clog2(NUM_QUEUES + 1);
    localparam int QIW = $clog2(NUM_QUEUES);
    localparam int FW  = (SW > QW) ? SW : QW;
    localparam int OW  = $clog2(SEG_BYTES);
    localparam int RW  = SW + 2 * OW;
    localparam int BD  = NUM_SEGMENTS * SEG_BYTES;
    localparam int BAW = $clog2(BD);
    localparam int CW  = $clog2(NUM_SEGMENTS + 1);

    localparam logic [SW-1:0] SEG_NULL = SW'(NUM_SEGMENTS);
    localparam logic [QW-1:0] Q_NULL   = QW'(NUM_QUEUES);
    localparam logic [OW-1:0] OFF_LAST = OW'(SEG_BYTES - 1);

    logic [1:0]      cmd_reg;
    logic [5:0]      q_reg;
    logic [7:0]      byte_reg;
    logic [SW-1:0]   fsh_reg, fsh_next, fst_reg, fst_next;
    logic [QW-1:0]   fqh_reg, fqh_next, fqt_reg, fqt_next;
    logic [NUM_QUEUES-1:0]   alloc_reg, alloc_next;
    logic [NUM_QUEUES-1:0]   qf_vld_reg, qr_vld_reg;
    logic [NUM_SEGMENTS-1:0] sn_vld_reg;
    logic [FW-1:0]   qf_reg;
    logic [SW-1:0]   back_reg;
    logic [OW-1:0]   foff_reg, boff_reg;
    logic [SW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [SW-1:0]   link_addr_reg, link_addr_next, link_val_reg, link_val_next;
    logic [QW-1:0]   qlink_reg, qlink_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic [5:0]      res_id_reg, res_id_next;
    logic [7:0]      res_byte_reg, res_byte_next;
    logic [1:0]      out_status_reg;
    logic [5:0]      out_id_reg;
    logic [7:0]      out_byte_reg;
    logic            qf_rv_reg, qr_rv_reg, sn_rv_reg;
    logic [QIW-1:0]  q_raddr_reg;
    logic [SIW-1:0]  sn_raddr_reg;

    logic            qf_we, qr_we, sn_we, sn_re, q_re, b_we, b_re;
    logic [QIW-1:0]  qf_waddr, qr_waddr, q_raddr;
    logic [FW-1:0]   qf_wdata, qf_rdata;
    logic [RW-1:0]   qr_wdata, qr_rdata;
    logic [SIW-1:0]  sn_waddr, sn_raddr;
    logic [SW-1:0]   sn_wdata, sn_rdata;
    logic [BAW-1:0]  b_waddr, b_raddr;
    logic [7:0]      b_wdata, b_rdata;

    logic [QIW-1:0]  q_idx, fqh_idx;
    logic            q_ok;
    logic [FW-1:0]   qf_word;
    logic [RW-1:0]   qr_word;
    logic [SW-1:0]   w_back;
    logic [OW-1:0]   w_foff, w_boff;
    logic [SW-1:0]   sn_word;
    logic [SW-1:0]   front_seg;
    logic            enq_need_new, deq_last, rel_en;
    logic [SW-1:0]   rel_seg;

    assign q_idx    = QIW'(q_reg);
    assign fqh_idx  = QIW'(fqh_reg);
    assign q_ok     = (32'(q_reg) < NUM_QUEUES) && alloc_reg[q_idx];
    assign qf_word  = qf_rv_reg ? qf_rdata : FW'(32'(q_raddr_reg) + 1);
    assign qr_word  = qr_rv_reg ? qr_rdata : {SEG_NULL, OW'(0), OW'(0)};
    assign {w_back, w_foff, w_boff} = qr_word;
    assign sn_word  = sn_rv_reg ? sn_rdata : SW'(32'(sn_raddr_reg) + 1);
    assign front_seg = SW'(qf_reg);
    assign enq_need_new = (32'(w_back) >= NUM_SEGMENTS) || (32'(w_boff) >= SEG_BYTES - 1);
    assign deq_last = (front_seg == back_reg) && (foff_reg == boff_reg);

    always_comb
    begin
        flags.go_take  = (cmd_reg == CMD_ENQ) && q_ok && (32'(w_boff) < SEG_BYTES)
                         && enq_need_new && (32'(fsh_reg) < NUM_SEGMENTS);
        flags.go_deq   = (cmd_reg == CMD_DEQ) && q_ok && (32'(qf_word) < NUM_SEGMENTS)
                         && (32'(w_foff) < SEG_BYTES);
        flags.go_dst   = (cmd_reg == CMD_DESTROY) && q_ok;
        flags.deq_rel  = deq_last || (foff_reg == OFF_LAST);
        flags.enq_link = (32'(back_reg) < NUM_SEGMENTS);
        flags.is_dst   = (cmd_reg == CMD_DESTROY);
        flags.dst_end  = (32'(cur_reg) >= NUM_SEGMENTS) || (32'(cnt_reg) == NUM_SEGMENTS);
    end

    always_comb
    begin
        fsh_next        = fsh_reg;
        fst_next        = fst_reg;
        fqh_next        = fqh_reg;
        fqt_next        = fqt_reg;
        alloc_next      = alloc_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        link_addr_next  = link_addr_reg;
        link_val_next   = link_val_reg;
        qlink_next      = qlink_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_byte_next   = res_byte_reg;
        qf_we = 1'b0; qf_waddr = q_idx; qf_wdata = '0;
        qr_we = 1'b0; qr_waddr = q_idx; qr_wdata = '0;
        sn_we = 1'b0; sn_waddr = '0;    sn_wdata = SEG_NULL;
        sn_re = 1'b0; sn_raddr = '0;
        b_we  = 1'b0; b_waddr  = '0;    b_wdata  = byte_reg;
        b_re  = 1'b0; b_raddr  = '0;
        q_re  = 1'b0;
        q_raddr = (cmd_reg == CMD_CREATE) ? fqh_idx : q_idx;
        rel_en  = 1'b0;
        rel_seg = (ctrl.op == OP_DEQ_READ) ? front_seg : cur_reg;

        if (ctrl.accept)
        begin
            res_status_next = STAT_OK;
            res_id_next     = '0;
            res_byte_next   = '0;
        end

        unique case (ctrl.op)
            OP_LOOKUP:
            begin
                q_re = 1'b1;
            end
            OP_EVAL:
            begin
                if (cmd_reg == CMD_CREATE)
                begin
                    if (32'(fqh_reg) >= NUM_QUEUES)
                    begin
                        res_status_next = STAT_OOM;
                    end
                    else
                    begin
                        res_id_next = 6'(fqh_reg);
                        fqh_next    = QW'(qf_word);
                        if (fqh_reg == fqt_reg)
                        begin
                            fqt_next = Q_NULL;
                        end
                        qf_we    = 1'b1;
                        qf_waddr = fqh_idx;
                        qf_wdata = FW'(SEG_NULL);
                        qr_we    = 1'b1;
                        qr_waddr = fqh_idx;
                        qr_wdata = {SEG_NULL, OW'(0), OW'(0)};
                        alloc_next[fqh_idx] = 1'b1;
                    end
                end
                else if (!q_ok)
                begin
                    res_status_next = STAT_ILLEGAL;
                end
                else if (cmd_reg == CMD_ENQ)
                begin
                    if (32'(w_boff) >= SEG_BYTES)
                    begin
                        res_status_next = STAT_ILLEGAL;
                    end
                    else if (enq_need_new)
                    begin
                        if (32'(fsh_reg) >= NUM_SEGMENTS)
                        begin
                            res_status_next = STAT_OOM;
                        end
                        else
                        begin
                            sn_re    = 1'b1;
                            sn_raddr = SIW'(fsh_reg);
                        end
                    end
                    else
                    begin
                        qr_we    = 1'b1;
                        qr_wdata = {w_back, w_foff, w_boff + OW'(1)};
                        b_we     = 1'b1;
                        b_waddr  = BAW'(32'(w_back) * SEG_BYTES + 32'(w_boff) + 1);
                    end
                end
                else if (cmd_reg == CMD_DEQ)
                begin
                    if ((32'(qf_word) >= NUM_SEGMENTS) || (32'(w_foff) >= SEG_BYTES))
                    begin
                        res_status_next = STAT_ILLEGAL;
                    end
                    else
                    begin
                        b_re     = 1'b1;
                        b_raddr  = BAW'(32'(qf_word) * SEG_BYTES + 32'(w_foff));
                        sn_re    = 1'b1;
                        sn_raddr = SIW'(qf_word);
                    end
                end
                else
                begin
                    cur_next = SW'(qf_word);
                    cnt_next = '0;
                end
            end
            OP_ENQ_TAKE:
            begin
                fsh_next = sn_word;
                if (fsh_reg == fst_reg)
                begin
                    fst_next = SEG_NULL;
                end
                sn_we    = 1'b1;
                sn_waddr = SIW'(fsh_reg);
                sn_wdata = SEG_NULL;
                b_we     = 1'b1;
                b_waddr  = BAW'(32'(fsh_reg) * SEG_BYTES);
                qr_we    = 1'b1;
                if (32'(back_reg) >= NUM_SEGMENTS)
                begin
                    qr_wdata = {fsh_reg, OW'(0), OW'(0)};
                    qf_we    = 1'b1;
                    qf_wdata = FW'(fsh_reg);
                end
                else
                begin
                    qr_wdata = {fsh_reg, foff_reg, OW'(0)};
                end
                link_addr_next = back_reg;
                link_val_next  = fsh_reg;
            end
            OP_DEQ_READ:
            begin
                res_byte_next = b_rdata;
                qr_we = 1'b1;
                if (deq_last)
                begin
                    qf_we    = 1'b1;
                    qf_wdata = FW'(SEG_NULL);
                    qr_wdata = {SEG_NULL, foff_reg, boff_reg};
                    rel_en   = 1'b1;
                end
                else if (foff_reg == OFF_LAST)
                begin
                    qf_we    = 1'b1;
                    qf_wdata = FW'(sn_word);
                    qr_wdata = {back_reg, OW'(0), boff_reg};
                    rel_en   = 1'b1;
                end
                else
                begin
                    qr_wdata = {back_reg, foff_reg + OW'(1), boff_reg};
                end
            end
            OP_LINK:
            begin
                if (32'(link_addr_reg) < NUM_SEGMENTS)
                begin
                    sn_we    = 1'b1;
                    sn_waddr = SIW'(link_addr_reg);
                    sn_wdata = link_val_reg;
                end
            end
            OP_DST_READ:
            begin
                if (!flags.dst_end)
                begin
                    sn_re    = 1'b1;
                    sn_raddr = SIW'(cur_reg);
                end
            end
            OP_DST_FREE:
            begin
                rel_en   = 1'b1;
                cur_next = sn_word;
                cnt_next = cnt_reg + CW'(1);
            end
            OP_DST_QUEUE:
            begin
                qf_we    = 1'b1;
                qf_wdata = FW'(Q_NULL);
                qr_we    = 1'b1;
                qr_wdata = {SEG_NULL, OW'(0), OW'(0)};
                alloc_next[q_idx] = 1'b0;
                qlink_next = fqt_reg;
                fqt_next   = QW'(q_reg);
                if (32'(fqt_reg) >= NUM_QUEUES)
                begin
                    fqh_next = QW'(q_reg);
                end
            end
            OP_DST_QLINK:
            begin
                if (32'(qlink_reg) < NUM_QUEUES)
                begin
                    qf_we    = 1'b1;
                    qf_waddr = QIW'(qlink_reg);
                    qf_wdata = FW'(q_reg);
                end
            end
            default:
            begin
            end
        endcase

        if (rel_en)
        begin
            sn_we          = 1'b1;
            sn_waddr       = SIW'(rel_seg);
            sn_wdata       = SEG_NULL;
            link_addr_next = fst_reg;
            link_val_next  = rel_seg;
            fst_next       = rel_seg;
            if (32'(fst_reg) >= NUM_SEGMENTS)
            begin
                fsh_next = rel_seg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsh_reg    <= '0;
            fst_reg    <= SW'(NUM_SEGMENTS - 1);
            fqh_reg    <= '0;
            fqt_reg    <= QW'(NUM_QUEUES - 1);
            alloc_reg  <= '0;
            qf_vld_reg <= '0;
            qr_vld_reg <= '0;
            sn_vld_reg <= '0;
        end
        else
        begin
            fsh_reg   <= fsh_next;
            fst_reg   <= fst_next;
            fqh_reg   <= fqh_next;
            fqt_reg   <= fqt_next;
            alloc_reg <= alloc_next;
            if (qf_we) qf_vld_reg[qf_waddr] <= 1'b1;
            if (qr_we) qr_vld_reg[qr_waddr] <= 1'b1;
            if (sn_we) sn_vld_reg[sn_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg  <= cmd;
            q_reg    <= queue_id;
            byte_reg <= data_byte;
        end
        if (ctrl.op == OP_EVAL)
        begin
            qf_reg   <= qf_word;
            back_reg <= w_back;
            foff_reg <= w_foff;
            boff_reg <= w_boff;
        end
        if (q_re)
        begin
            qf_rv_reg   <= qf_vld_reg[q_raddr];
            qr_rv_reg   <= qr_vld_reg[q_raddr];
            q_raddr_reg <= q_raddr;
        end
        if (sn_re)
        begin
            sn_rv_reg    <= sn_vld_reg[sn_raddr];
            sn_raddr_reg <= sn_raddr;
        end
        if (ctrl.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_byte_reg   <= res_byte_reg;
        end
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        link_addr_reg  <= link_addr_next;
        link_val_reg   <= link_val_next;
        qlink_reg      <= qlink_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_byte_reg   <= res_byte_next;
    end

    lsmq_ram #(.WIDTH(FW), .DEPTH(NUM_QUEUES)) u_qfront (
        .clk(clk), .wr_en(qf_we), .wr_addr(qf_waddr), .wr_data(qf_wdata),
        .rd_en(q_re), .rd_addr(q_raddr), .rd_data(qf_rdata)
    );

    lsmq_ram #(.WIDTH(RW), .DEPTH(NUM_QUEUES)) u_qrest (
        .clk(clk), .wr_en(qr_we), .wr_addr(qr_waddr), .wr_data(qr_wdata),
        .rd_en(q_re), .rd_addr(q_raddr), .rd_data(qr_rdata)
    );

    lsmq_ram #(.WIDTH(SW), .DEPTH(NUM_SEGMENTS)) u_snext (
        .clk(clk), .wr_en(sn_we), .wr_addr(sn_waddr), .wr_data(sn_wdata),
        .rd_en(sn_re), .rd_addr(sn_raddr), .rd_data(sn_rdata)
    );

    lsmq_ram #(.WIDTH(8), .DEPTH(BD)) u_bytes (
        .clk(clk), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(b_wdata),
        .rd_en(b_re), .rd_addr(b_raddr), .rd_data(b_rdata)
    );

    assign status       = out_status_reg;
    assign new_queue_id = out_id_reg;
    assign read_byte    = out_byte_reg;

endmodule

// ===== design/linked_segment_multi_queue_core.sv =====
`timescale 1ns / 1ps
// Top level of the linked segment multi queue: controller plus datapath.
// Depends on lsmq_pkg, lsmq_ctrl, lsmq_dp and lsmq_ram.
//
// Byte FIFOs share one buffer of fixed-size segments chained by next
// pointers; commands are create, destroy, enqueue and dequeue, one result
// word per command word. One command is in work at a time. Every command
// passes lookup and evaluation; create, an enqueue into the current segment
// and any rejected command then finish. A dequeue reads its byte and, when it
// frees a segment, relinks the free list; an enqueue that opens a segment
// takes it from the free list and links it behind an existing back segment.
// Destroy reads, frees and relinks each segment on the chain, then returns the
// queue to the free queue list. The next word can be accepted in the cycle
// after its result is loaded. The next-pointer RAM, one read and one write per
// cycle with registered read, serializes each segment read, free and relink.
// Tables come out of reset ready to use; no clearing pass is run. The result
// register lets the next word be accepted while a result still waits.
module linked_segment_multi_queue_core
    import lsmq_pkg::*;
#(
    parameter int NUM_SEGMENTS = 128,
    parameter int SEG_BYTES    = 16,
    parameter int NUM_QUEUES   = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [5:0] queue_id,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [5:0] new_queue_id,
    output logic [7:0] read_byte
);

    dp_ctrl_t   ctrl;
    dp_flags_t  flags;

    lsmq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .flags(flags), .ctrl(ctrl)
    );

    lsmq_dp #(
        .NUM_SEGMENTS(NUM_SEGMENTS),
        .SEG_BYTES(SEG_BYTES),
        .NUM_QUEUES(NUM_QUEUES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .ctrl(ctrl), .flags(flags),
        .cmd(cmd), .queue_id(queue_id), .data_byte(data_byte),
        .status(status), .new_queue_id(new_queue_id), .read_byte(read_byte)
    );

endmodule

// ===== design/lsmq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the linked segment multi queue, bound to the top.
// Depends on lsmq_pkg and linked_segment_multi_queue_core.
module lsmq_checker
    import lsmq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [5:0] new_queue_id,
    input logic [7:0] read_byte
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(new_queue_id) && $stable(read_byte))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while one is in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> new_queue_id == 6'd0 && read_byte == 8'd0)
        else $error("failed command returned data");

endmodule

bind linked_segment_multi_queue_core lsmq_checker u_lsmq_checker (.*);
